// ===== rtl/dqsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqsr_pkg: shared types and constants of the double-ended queue
// Ring depth, index helpers, request codes and the result word layout.
// ----------------------------------------------------------------------------
package dqsr_pkg;

  localparam int DEPTH   = 32;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FIELD_W = 6;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_POP_BACK   = 2'd1,
    REQ_PUSH_FRONT = 2'd2,
    REQ_POP_FRONT  = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic                     accepted;
    logic [FIELD_W-1:0]       fill_count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic signed [DATA_W-1:0] sum_total;
    logic [FIELD_W-1:0]       run_count;
  } res_t;

  // Ring index step, valid for any depth, not only powers of two.
  function automatic idx_t idx_inc(input idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t idx_dec(input idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

// ===== rtl/dqsr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqsr_ram: generic RAM, one write port and two registered read ports
// A read of the address written in the same cycle returns the new word.
// ----------------------------------------------------------------------------
module dqsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                         rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr_a)) begin
      rdata_a <= wdata;
    end else begin
      rdata_a <= mem[raddr_a];
    end
    if (we && (waddr == raddr_b)) begin
      rdata_b <= wdata;
    end else begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/dqsr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqsr_core: ring pointers, running sum, descent count and end values
// Applies one request per cycle and presents the result word for it.
// ----------------------------------------------------------------------------
module dqsr_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  dqsr_pkg::req_kind_t               kind,
  input  logic signed [dqsr_pkg::DATA_W-1:0] value,
  output dqsr_pkg::res_t                    result
);

  dqsr_pkg::idx_t front_index, front_index_next;
  dqsr_pkg::idx_t back_index, back_index_next;
  dqsr_pkg::cnt_t held_count, held_count_next;
  dqsr_pkg::cnt_t descent_runs, descent_runs_next;
  logic signed [dqsr_pkg::DATA_W-1:0] running_sum, running_sum_next;
  logic signed [dqsr_pkg::DATA_W-1:0] front_val, front_val_next;
  logic signed [dqsr_pkg::DATA_W-1:0] back_val, back_val_next;

  // Neighbors of the two ends, fetched for the state that is current now.
  logic signed [dqsr_pkg::DATA_W-1:0] second_val, second_last_val;
  logic [dqsr_pkg::DATA_W-1:0]        rdata_a, rdata_b;

  logic           empty, full, ok, apply;
  logic           wr_en;
  dqsr_pkg::idx_t wr_addr;
  dqsr_pkg::cnt_t run_sum;

  assign second_val      = $signed(rdata_a);
  assign second_last_val = $signed(rdata_b);

  assign empty = (held_count == '0);
  assign full  = (held_count == dqsr_pkg::cnt_t'(dqsr_pkg::DEPTH));

  always_comb begin
    front_index_next  = front_index;
    back_index_next   = back_index;
    held_count_next   = held_count;
    descent_runs_next = descent_runs;
    running_sum_next  = running_sum;
    front_val_next    = front_val;
    back_val_next     = back_val;
    wr_en             = 1'b0;
    wr_addr           = dqsr_pkg::idx_inc(back_index);
    ok                = 1'b0;

    unique case (kind)
      dqsr_pkg::REQ_PUSH_BACK: begin
        ok = !full;
      end
      dqsr_pkg::REQ_PUSH_FRONT: begin
        ok = !full;
      end
      dqsr_pkg::REQ_POP_BACK: begin
        ok = !empty;
      end
      dqsr_pkg::REQ_POP_FRONT: begin
        ok = !empty;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    apply = fire && ok;

    if (apply) begin
      unique case (kind)
        dqsr_pkg::REQ_PUSH_BACK: begin
          if (!empty && (back_val > value)) begin
            descent_runs_next = dqsr_pkg::cnt_t'(descent_runs + 1'b1);
          end
          wr_en            = 1'b1;
          wr_addr          = dqsr_pkg::idx_inc(back_index);
          back_index_next  = dqsr_pkg::idx_inc(back_index);
          held_count_next  = dqsr_pkg::cnt_t'(held_count + 1'b1);
          running_sum_next = running_sum + value;
          back_val_next    = value;
          if (empty) begin
            front_val_next = value;
          end
        end
        dqsr_pkg::REQ_PUSH_FRONT: begin
          if (!empty && (value > front_val)) begin
            descent_runs_next = dqsr_pkg::cnt_t'(descent_runs + 1'b1);
          end
          wr_en            = 1'b1;
          wr_addr          = dqsr_pkg::idx_dec(front_index);
          front_index_next = dqsr_pkg::idx_dec(front_index);
          held_count_next  = dqsr_pkg::cnt_t'(held_count + 1'b1);
          running_sum_next = running_sum + value;
          front_val_next   = value;
          if (empty) begin
            back_val_next = value;
          end
        end
        dqsr_pkg::REQ_POP_BACK: begin
          if ((held_count >= dqsr_pkg::cnt_t'(2)) && (second_last_val > back_val)) begin
            descent_runs_next = dqsr_pkg::cnt_t'(descent_runs - 1'b1);
          end
          back_index_next  = dqsr_pkg::idx_dec(back_index);
          held_count_next  = dqsr_pkg::cnt_t'(held_count - 1'b1);
          running_sum_next = running_sum - back_val;
          back_val_next    = second_last_val;
        end
        dqsr_pkg::REQ_POP_FRONT: begin
          if ((held_count >= dqsr_pkg::cnt_t'(2)) && (front_val > second_val)) begin
            descent_runs_next = dqsr_pkg::cnt_t'(descent_runs - 1'b1);
          end
          front_index_next = dqsr_pkg::idx_inc(front_index);
          held_count_next  = dqsr_pkg::cnt_t'(held_count - 1'b1);
          running_sum_next = running_sum - front_val;
          front_val_next   = second_val;
        end
        default: begin
          held_count_next = held_count;
        end
      endcase
      if (held_count_next == '0) begin
        descent_runs_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index  <= '0;
      back_index   <= dqsr_pkg::idx_t'(dqsr_pkg::DEPTH - 1);
      held_count   <= '0;
      descent_runs <= '0;
      running_sum  <= '0;
    end else begin
      front_index  <= front_index_next;
      back_index   <= back_index_next;
      held_count   <= held_count_next;
      descent_runs <= descent_runs_next;
      running_sum  <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    front_val <= front_val_next;
    back_val  <= back_val_next;
  end

  // The read addresses follow the next state, so the neighbors of both ends
  // are ready in the cycle that state becomes current.
  dqsr_ram #(
    .WIDTH (dqsr_pkg::DATA_W),
    .DEPTH (dqsr_pkg::DEPTH)
  ) u_slots (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (value),
    .raddr_a (dqsr_pkg::idx_inc(front_index_next)),
    .rdata_a (rdata_a),
    .raddr_b (dqsr_pkg::idx_dec(back_index_next)),
    .rdata_b (rdata_b)
  );

  assign run_sum = dqsr_pkg::cnt_t'(descent_runs_next + 1'b1);

  always_comb begin
    result.accepted   = ok;
    result.fill_count = dqsr_pkg::FIELD_W'(held_count_next);
    result.sum_total  = running_sum_next;
    if (held_count_next == '0) begin
      result.front_value = '0;
      result.back_value  = '0;
      result.run_count   = '0;
    end else begin
      result.front_value = front_val_next;
      result.back_value  = back_val_next;
      result.run_count   = dqsr_pkg::FIELD_W'(run_sum);
    end
  end

endmodule

// ===== rtl/deque_with_sum_and_runs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_sum_and_runs: bounded double-ended queue with sum and run count
// Push and pop at either end of a ring store; each request returns one word.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   request   req_valid / req_stall  req_type, value
//   result    res_valid / res_stall  accepted, fill_count, front_value,
//                                    back_value, sum_total, run_count
//
// One request is taken per cycle while req_stall is low; its result word appears
// in the result register in the cycle after. The whole update (ring pointers,
// sum, descent count and both end values) is computed combinationally in the cycle the request is taken.
// Reset clears the pointers, counts and sum; the slot memory is not cleared.
// A request is taken whenever the result register is empty or drains in the
// same cycle; otherwise req_stall is raised.
module deque_with_sum_and_runs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [1:0]                         req_type,
  input  logic signed [dqsr_pkg::DATA_W-1:0] value,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic                               accepted,
  output logic [dqsr_pkg::FIELD_W-1:0]       fill_count,
  output logic signed [dqsr_pkg::DATA_W-1:0] front_value,
  output logic signed [dqsr_pkg::DATA_W-1:0] back_value,
  output logic signed [dqsr_pkg::DATA_W-1:0] sum_total,
  output logic [dqsr_pkg::FIELD_W-1:0]       run_count
);

  logic           fire;
  dqsr_pkg::res_t core_result;
  dqsr_pkg::res_t res_word;

  assign req_stall = res_valid && res_stall;
  assign fire      = req_valid && !req_stall;

  dqsr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .kind   (dqsr_pkg::req_kind_t'(req_type)),
    .value  (value),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_word <= core_result;
    end
  end

  assign accepted    = res_word.accepted;
  assign fill_count  = res_word.fill_count;
  assign front_value = res_word.front_value;
  assign back_value  = res_word.back_value;
  assign sum_total   = res_word.sum_total;
  assign run_count   = res_word.run_count;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the double-ended queue with sum and runs
// A short table of directed requests is followed by random bursts that fill,
// drain and churn the ring. Every result word is checked against an in-bench
// model (typed rows: a fixed word), with varying idle/stall on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import dqsr_pkg::*;

  localparam int RAND_ITEMS     = 1100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [DATA_W-1:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MINV = 32'sh8000_0000;
  localparam res_t RES_EMPTY = '0;

  typedef enum int {FILL_BURST, DRAIN_BURST, MIXED_BURST, FALLING_BURST} burst_kind_t;

  typedef struct {
    req_kind_t                kind;
    logic signed [DATA_W-1:0] val;
    bit                       typed;
    res_t                     want;
  } plan_row_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [1:0]               req_type = 2'd0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  logic                     accepted;
  logic [FIELD_W-1:0]       fill_count;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic signed [DATA_W-1:0] sum_total;
  logic [FIELD_W-1:0]       run_count;

  deque_with_sum_and_runs uut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .value       (value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .accepted    (accepted),
    .fill_count  (fill_count),
    .front_value (front_value),
    .back_value  (back_value),
    .sum_total   (sum_total),
    .run_count   (run_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Model of the queue contents, advanced once per accepted request word.
  logic signed [DATA_W-1:0] ring_model [DEPTH];
  int                       front_at = 0;
  int                       held_n = 0;
  int                       descents = 0;
  logic signed [DATA_W-1:0] sum_model = '0;

  res_t pending_words [$];
  int   send_idle_pct = 34;
  int   recv_idle_pct = 86;
  int   mismatches = 0;
  int   words_checked = 0;
  int   quiet_cycles = 0;
  int   dropped_pushes = 0;
  int   empty_pops = 0;
  int   peak_runs = 0;

  function automatic int slot_at(input int pos);
    return (front_at + pos) % DEPTH;
  endfunction

  function automatic res_t queue_after(input req_kind_t kind,
                                       input logic signed [DATA_W-1:0] v);
    res_t                     r;
    logic signed [DATA_W-1:0] gone;
    r = RES_EMPTY;
    case (kind)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (held_n < DEPTH) begin
          if (kind == REQ_PUSH_BACK) begin
            if (held_n > 0 && ring_model[slot_at(held_n - 1)] > v) descents++;
            ring_model[slot_at(held_n)] = v;
          end else begin
            if (held_n > 0 && v > ring_model[slot_at(0)]) descents++;
            front_at = (front_at + DEPTH - 1) % DEPTH;
            ring_model[front_at] = v;
          end
          held_n++;
          sum_model += v;
          r.accepted = 1'b1;
        end
      end
      default: begin
        if (held_n > 0) begin
          if (kind == REQ_POP_BACK) begin
            gone = ring_model[slot_at(held_n - 1)];
            if (held_n >= 2 && ring_model[slot_at(held_n - 2)] > gone) descents--;
          end else begin
            gone = ring_model[slot_at(0)];
            if (held_n >= 2 && gone > ring_model[slot_at(1)]) descents--;
            front_at = (front_at + 1) % DEPTH;
          end
          held_n--;
          sum_model -= gone;
          if (held_n == 0) descents = 0;
          r.accepted = 1'b1;
        end
      end
    endcase
    r.fill_count = FIELD_W'(held_n);
    r.sum_total  = sum_model;
    if (held_n > 0) begin
      r.front_value = ring_model[slot_at(0)];
      r.back_value  = ring_model[slot_at(held_n - 1)];
      r.run_count   = FIELD_W'(1 + descents);
    end
    return r;
  endfunction

  function automatic plan_row_t plan_row(input req_kind_t kind,
                                         input logic signed [DATA_W-1:0] val,
                                         input bit typed = 1'b0,
                                         input res_t want = '0);
    plan_row_t p;
    p.kind  = kind;
    p.val   = val;
    p.typed = typed;
    p.want  = want;
    return p;
  endfunction

  // Extremes, small values that produce equal neighbors, and full-range noise.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0:       return $urandom_range(1) ? MAXV : MINV;
      1, 2:    return DATA_W'($urandom_range(8)) - 32'sd4;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input req_kind_t kind, input logic signed [DATA_W-1:0] val,
                           input bit typed, input res_t typed_want);
    res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    value     <= val;
    do @(posedge clk); while (req_stall);
    want = queue_after(kind, val);
    if (!want.accepted) begin
      if (kind == REQ_PUSH_BACK || kind == REQ_PUSH_FRONT) dropped_pushes++;
      else empty_pops++;
    end
    if (int'(want.run_count) > peak_runs) peak_runs = want.run_count;
    pending_words.insert(pending_words.size(), typed ? typed_want : want);
  endtask

  // Result side: random stalls, word checks and the watchdog.
  always @(posedge clk) begin
    res_t got;
    res_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst) begin
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_words.size());
        $display("** deque_with_sum_and_runs: FAILED **");
        $finish;
      end else if (res_valid && !res_stall) begin
        got = '{accepted, fill_count, front_value, back_value, sum_total, run_count};
        words_checked++;
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result word at %0t: acc=%0b fill=%0d", $realtime,
                     got.accepted, got.fill_count);
        end else if (got !== pending_words[0]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch on word %0d: expected acc=%0b fill=%0d front=%0d back=%0d sum=%0d runs=%0d",
                     words_checked, pending_words[0].accepted, pending_words[0].fill_count,
                     pending_words[0].front_value, pending_words[0].back_value,
                     pending_words[0].sum_total, pending_words[0].run_count);
            $display("                   got      acc=%0b fill=%0d front=%0d back=%0d sum=%0d runs=%0d",
                     got.accepted, got.fill_count, got.front_value, got.back_value,
                     got.sum_total, got.run_count);
          end
          pending_words.delete(0);
        end else begin
          pending_words.delete(0);
        end
      end
    end
  end

  initial begin
    plan_row_t   plan [$];
    burst_kind_t mode;
    int          burst_len;
    int          push_pct;
    int          rand_done;
    int          sent;
    req_kind_t   kind;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] falling_val;

    rand_done = 0;
    sent = 0;
    plan = '{
      plan_row(REQ_POP_BACK,   32'sd0, 1'b1, RES_EMPTY),
      plan_row(REQ_POP_FRONT,  -32'sd1, 1'b1, RES_EMPTY),
      plan_row(REQ_PUSH_BACK,  MAXV, 1'b1, res_t'{1'b1, 6'd1, MAXV, MAXV, MAXV, 6'd1}),
      plan_row(REQ_PUSH_BACK,  MINV),
      plan_row(REQ_PUSH_FRONT, MINV),
      plan_row(REQ_PUSH_FRONT, MAXV),
      plan_row(REQ_PUSH_BACK,  32'sd0),
      plan_row(REQ_PUSH_BACK,  -32'sd1),
      plan_row(REQ_PUSH_FRONT, 32'sh5555_5555),
      plan_row(REQ_PUSH_BACK,  32'shAAAA_AAAA),
      plan_row(REQ_PUSH_BACK,  32'shAAAA_AAAA),
      plan_row(REQ_POP_FRONT,  32'sd7),
      plan_row(REQ_POP_BACK,   32'sd0),
      plan_row(REQ_POP_FRONT,  32'sd0),
      plan_row(REQ_POP_BACK,   MAXV),
      plan_row(REQ_POP_FRONT,  32'sd0),
      plan_row(REQ_POP_BACK,   32'sd0),
      plan_row(REQ_POP_FRONT,  MINV),
      plan_row(REQ_POP_BACK,   32'sd0),
      plan_row(REQ_POP_FRONT,  32'sd0),
      plan_row(REQ_POP_FRONT,  32'sd0, 1'b1, RES_EMPTY),
      plan_row(REQ_PUSH_FRONT, MINV, 1'b1, res_t'{1'b1, 6'd1, MINV, MINV, MINV, 6'd1}),
      plan_row(REQ_PUSH_FRONT, MINV),
      plan_row(REQ_POP_BACK,   32'sd0),
      plan_row(REQ_POP_BACK,   32'sd0)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_word(plan[i].kind, plan[i].val, plan[i].typed, plan[i].want);
      sent++;
    end

    // Random bursts: filling ones reach the full case, draining ones the empty
    // case, and falling ones stack descents toward the largest run count.
    while (rand_done < RAND_ITEMS) begin
      if (rand_done >= 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (rand_done >= RAND_ITEMS / 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 34;
      end
      mode        = burst_kind_t'($urandom_range(3));
      burst_len   = $urandom_range(8, 48);
      falling_val = pick_value();
      case (mode)
        FILL_BURST:    push_pct = 85;
        DRAIN_BURST:   push_pct = 15;
        FALLING_BURST: push_pct = 90;
        default:       push_pct = 50;
      endcase
      repeat (burst_len) begin
        if ($urandom_range(99) < push_pct) begin
          if (mode == FALLING_BURST) begin
            falling_val = falling_val - DATA_W'($urandom_range(1, 5));
            kind = REQ_PUSH_BACK;
            val  = falling_val;
          end else begin
            kind = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            val  = pick_value();
          end
        end else begin
          kind = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
          val  = $urandom();
        end
        send_word(kind, val, 1'b0, RES_EMPTY);
        sent++;
        rand_done++;
      end
    end

    req_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d requests (%0d from the table); %0d result words checked, %0d mismatches.",
             sent, plan.size(), words_checked, mismatches);
    $display("Dropped pushes on a full queue: %0d, pops on an empty queue: %0d, peak run count: %0d.",
             dropped_pushes, empty_pops, peak_runs);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("** deque_with_sum_and_runs: PASSED **");
    end else begin
      $display("** deque_with_sum_and_runs: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dqsr_pkg.sv
rtl/dqsr_ram.sv
rtl/dqsr_core.sv
rtl/deque_with_sum_and_runs.sv
tb/tb_top.sv
